@@ rtl/srdh_pkg.sv @@
// Shared types and widths for the segment / rectangle-diagonal hit pipeline.
// No dependencies.
package srdh_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
  localparam int EXT_WIDTH   = COORD_WIDTH + 1;     // corner = x + w
  localparam int DIFF_WIDTH  = COORD_WIDTH + 2;     // difference of two corners
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;      // product of two differences
  localparam int DET_WIDTH   = PROD_WIDTH + 1;      // difference of two products

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [SIZE_WIDTH-1:0]  size_t;
  typedef logic signed [EXT_WIDTH-1:0]   ext_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [DET_WIDTH-1:0]   det_t;

  typedef struct packed {
    ext_t x;
    ext_t y;
  } pt_t;

  // Per-stage load strobes handed to each orientation lane.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } srdh_adv_t;

  // Sign of one determinant plus the matching bounding-box flag.
  typedef struct packed {
    logic zero;
    logic neg;
    logic box;
  } orient_t;

  // Hit test for one diagonal from its four orientation results.
  function automatic logic seg_hit(orient_t o1, orient_t o2, orient_t o3, orient_t o4);
    logic proper;
    logic touch;
    proper = !o1.zero && !o2.zero && (o1.neg != o2.neg) &&
             !o3.zero && !o4.zero && (o3.neg != o4.neg);
    touch  = (o1.zero && o1.box) || (o2.zero && o2.box) ||
             (o3.zero && o3.box) || (o4.zero && o4.box);
    return proper || touch;
  endfunction

endpackage

@@ rtl/srdh_orient.sv @@
// One orientation lane: differences, products, determinant sign, box check.
// Depends on srdh_pkg.
module srdh_orient import srdh_pkg::*; (
  input  logic      clk,
  input  srdh_adv_t adv,
  input  pt_t       a,
  input  pt_t       b,
  input  pt_t       c,
  output orient_t   res
);

  diff_t u, v, p, q;
  logic  box2, box3;
  prod_t pu, pq;
  det_t  det;

  // stage 2: operand differences and bounding-box test
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      u    <= diff_t'(c.x) - diff_t'(a.x);
      v    <= diff_t'(b.y) - diff_t'(a.y);
      p    <= diff_t'(b.x) - diff_t'(a.x);
      q    <= diff_t'(c.y) - diff_t'(a.y);
      box2 <= ((a.x <= c.x && c.x <= b.x) || (b.x <= c.x && c.x <= a.x)) &&
              ((a.y <= c.y && c.y <= b.y) || (b.y <= c.y && c.y <= a.y));
    end
  end

  // stage 3: the two cross products
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pu   <= prod_t'(u) * prod_t'(v);
      pq   <= prod_t'(p) * prod_t'(q);
      box3 <= box2;
    end
  end

  assign det = det_t'(pu) - det_t'(pq);

  // stage 4: sign of the determinant
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      res.zero <= (det == '0);
      res.neg  <= det[DET_WIDTH-1];
      res.box  <= box3;
    end
  end

endmodule

@@ rtl/segment_rectangle_diagonal_hit_core.sv @@
// Top level: segment versus rectangle-diagonal hit test, five-stage pipeline.
// Depends on srdh_pkg and srdh_orient.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | seg_start_x/y, seg_end_x/y, rect_x/y, rect_w/h
//  out     | out_valid / out_ready| hit
//
// One beat in and one beat out per cycle, sustained while out_ready stays high.
// Five register stages: corner registers, difference registers, the 18x18
// multipliers, the determinant subtract/sign, then the output register.
// rst (synchronous) clears only the stage valid bits; data registers are free.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out under a stall and in_ready stays high until all stages fill.
module segment_rectangle_diagonal_hit_core import srdh_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t seg_start_x,
  input  coord_t seg_start_y,
  input  coord_t seg_end_x,
  input  coord_t seg_end_y,
  input  coord_t rect_x,
  input  coord_t rect_y,
  input  size_t  rect_w,
  input  size_t  rect_h,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   hit
);

  // stage valid bits
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  srdh_adv_t adv;

  // stage 1 registers: segment endpoints and the four rectangle corners
  pt_t  s, e;
  ext_t rx, ry, rx2, ry2;
  pt_t  d0a, d0b, d1a, d1b;

  // orientation results: [diag*4 + k], k = o1..o4
  orient_t orr [8];
  logic    hit_next;

  // ready chain, back to front
  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // stage 1: sign-extend coordinates, form far corner (x + w, y + h)
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s.x <= ext_t'(seg_start_x);
      s.y <= ext_t'(seg_start_y);
      e.x <= ext_t'(seg_end_x);
      e.y <= ext_t'(seg_end_y);
      rx  <= ext_t'(rect_x);
      ry  <= ext_t'(rect_y);
      rx2 <= ext_t'(rect_x) + $signed({2'b00, rect_w});
      ry2 <= ext_t'(rect_y) + $signed({2'b00, rect_h});
    end
  end

  // diagonal 0: (x, y)-(x+w, y+h); diagonal 1: (x, y+h)-(x+w, y)
  assign d0a = '{x: rx,  y: ry};
  assign d0b = '{x: rx2, y: ry2};
  assign d1a = '{x: rx,  y: ry2};
  assign d1b = '{x: rx2, y: ry};

  // o1 = orient(a,b,s), o2 = orient(a,b,e), o3 = orient(s,e,a), o4 = orient(s,e,b)
  srdh_orient u_o0 (.clk(clk), .adv(adv), .a(d0a), .b(d0b), .c(s),   .res(orr[0]));
  srdh_orient u_o1 (.clk(clk), .adv(adv), .a(d0a), .b(d0b), .c(e),   .res(orr[1]));
  srdh_orient u_o2 (.clk(clk), .adv(adv), .a(s),   .b(e),   .c(d0a), .res(orr[2]));
  srdh_orient u_o3 (.clk(clk), .adv(adv), .a(s),   .b(e),   .c(d0b), .res(orr[3]));
  srdh_orient u_o4 (.clk(clk), .adv(adv), .a(d1a), .b(d1b), .c(s),   .res(orr[4]));
  srdh_orient u_o5 (.clk(clk), .adv(adv), .a(d1a), .b(d1b), .c(e),   .res(orr[5]));
  srdh_orient u_o6 (.clk(clk), .adv(adv), .a(s),   .b(e),   .c(d1a), .res(orr[6]));
  srdh_orient u_o7 (.clk(clk), .adv(adv), .a(s),   .b(e),   .c(d1b), .res(orr[7]));

  // stage 5: crossing / touching decision per diagonal, into the output register
  assign hit_next = seg_hit(orr[0], orr[1], orr[2], orr[3]) ||
                    seg_hit(orr[4], orr[5], orr[6], orr[7]);

  always_ff @(posedge clk) begin
    if (rdy5) begin
      hit <= hit_next;
    end
  end

`ifndef SYNTHESIS
  // input only stalls when every stage is full and the output is blocked
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4 && out_valid))
    else $error("in_ready low with an empty stage");

  // an accepted beat lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted beat lost at stage 1");

  // a blocked output keeps the beat behind it
  a_hold_stage4: assert property (@(posedge clk) disable iff (rst)
    (v4 && out_valid && !out_ready) |=> (v4 && out_valid))
    else $error("stage 4 beat dropped under stall");
`endif

endmodule

@@ dv/segment_rectangle_diagonal_hit_core_test.sv @@
// Self-checking bench for segment_rectangle_diagonal_hit_core: predicts the
// diagonal hit bit per query and checks every output beat in order.
// Depends on srdh_pkg (coord_t, size_t) and the core RTL.
`timescale 1ns / 100ps

module segment_rectangle_diagonal_hit_core_test;

  typedef srdh_pkg::coord_t coord_t;
  typedef srdh_pkg::size_t  size_t;

  // One collision query as it sits on the input ports.
  typedef struct {
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t rect_x;
    coord_t rect_y;
    size_t  rect_w;
    size_t  rect_h;
  } query_t;

  // Holds the predicted hit bit of every accepted query, oldest first.
  class hit_scoreboard;
    bit expected_hits[$];
    int failures;

    // Sign of (c - a) x (b - a); coordinates are at most 18 bits, so the
    // products fit easily in 64 bits.
    function int turn_sign(longint ax, longint ay, longint bx, longint by,
                           longint cx, longint cy);
      longint det;
      det = (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
      return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
    endfunction

    // Point c inside the box spanned by a and b, edges included.
    function bit within_bounds(longint ax, longint ay, longint bx, longint by,
                               longint cx, longint cy);
      longint xl, xh, yl, yh;
      xl = (ax < bx) ? ax : bx;
      xh = (ax < bx) ? bx : ax;
      yl = (ay < by) ? ay : by;
      yh = (ay < by) ? by : ay;
      return xl <= cx && cx <= xh && yl <= cy && cy <= yh;
    endfunction

    // Diagonal a-b against segment s-e: proper crossing or touching endpoint.
    function bit diagonal_touched(longint ax, longint ay, longint bx, longint by,
                                  longint sx, longint sy, longint ex, longint ey);
      int o1, o2, o3, o4;
      o1 = turn_sign(ax, ay, bx, by, sx, sy);
      o2 = turn_sign(ax, ay, bx, by, ex, ey);
      o3 = turn_sign(sx, sy, ex, ey, ax, ay);
      o4 = turn_sign(sx, sy, ex, ey, bx, by);
      if (o1 * o2 < 0 && o3 * o4 < 0) return 1'b1;
      if (o1 == 0 && within_bounds(ax, ay, bx, by, sx, sy)) return 1'b1;
      if (o2 == 0 && within_bounds(ax, ay, bx, by, ex, ey)) return 1'b1;
      if (o3 == 0 && within_bounds(sx, sy, ex, ey, ax, ay)) return 1'b1;
      if (o4 == 0 && within_bounds(sx, sy, ex, ey, bx, by)) return 1'b1;
      return 1'b0;
    endfunction

    function bit predict_hit(query_t q);
      longint sx, sy, ex, ey, x0, y0, x1, y1;
      sx = longint'(q.seg_start_x);
      sy = longint'(q.seg_start_y);
      ex = longint'(q.seg_end_x);
      ey = longint'(q.seg_end_y);
      x0 = longint'(q.rect_x);
      y0 = longint'(q.rect_y);
      x1 = x0 + longint'(q.rect_w);   // size is unsigned, zero-extends
      y1 = y0 + longint'(q.rect_h);
      return diagonal_touched(x0, y0, x1, y1, sx, sy, ex, ey) ||
             diagonal_touched(x0, y1, x1, y0, sx, sy, ex, ey);
    endfunction

    function void note_query(query_t q);
      expected_hits.push_back(predict_hit(q));
    endfunction

    function void check_hit(logic actual);
      bit want;
      if (expected_hits.size() == 0) begin
        $error("hit: beat with no query outstanding, actual %0b", actual);
        failures++;
        return;
      end
      want = expected_hits.pop_front();
      if (actual !== want) begin
        $error("hit: expected %0b actual %0b", want, actual);
        failures++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t seg_start_x = '0;
  coord_t seg_start_y = '0;
  coord_t seg_end_x   = '0;
  coord_t seg_end_y   = '0;
  coord_t rect_x      = '0;
  coord_t rect_y      = '0;
  size_t  rect_w      = '0;
  size_t  rect_h      = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   hit;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  segment_rectangle_diagonal_hit_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit)
  );

  hit_scoreboard hits = new();

  // Idle pattern state. Each side draws runs at random, some with random gaps
  // and some with none, so both dense and sparse traffic show up.
  int tx_run_left = 0;
  bit tx_dense    = 1'b0;
  int rx_run_left = 0;
  bit rx_dense    = 1'b0;
  int rx_hold_request = 0;   // one-shot long stall, picked up by the receiver

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function int draw_tx_gap();
    if (tx_run_left == 0) begin
      tx_dense    = ($urandom_range(0, 3) == 0);
      tx_run_left = $urandom_range(10, 60);
    end
    tx_run_left--;
    return tx_dense ? 0 : $urandom_range(0, 12);
  endfunction

  // Offer one query beat. Called right after a rising edge; in_valid either
  // stays high into the next beat (no gap) or drops for the gap, never both.
  task automatic send_query(query_t q, bit back_to_back);
    int gap;
    gap = back_to_back ? 0 : draw_tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_start_x <= q.seg_start_x;
    seg_start_y <= q.seg_start_y;
    seg_end_x   <= q.seg_end_x;
    seg_end_y   <= q.seg_end_y;
    rect_x      <= q.rect_x;
    rect_y      <= q.rect_y;
    rect_w      <= q.rect_w;
    rect_h      <= q.rect_h;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hits.note_query(q);
  endtask

  // Drop valid and sit still until every predicted hit has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (hits.expected_hits.size() != 0) @(posedge clk);
  endtask

  function query_t make_query(int sx, int sy, int ex, int ey,
                              int rx, int ry, int w, int h);
    query_t q;
    q.seg_start_x = coord_t'(sx);
    q.seg_start_y = coord_t'(sy);
    q.seg_end_x   = coord_t'(ex);
    q.seg_end_y   = coord_t'(ey);
    q.rect_x      = coord_t'(rx);
    q.rect_y      = coord_t'(ry);
    q.rect_w      = size_t'(w);
    q.rect_h      = size_t'(h);
    return q;
  endfunction

  // Random query: most often segments placed around the rectangle so hits,
  // misses and touches all come up; some tiny-grid cases for collinear and
  // degenerate shapes; some raw full-range noise for every bit.
  function query_t random_query();
    query_t q;
    int kind, w, h, x0, y0, corner;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      q = make_query($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end else if (kind <= 4) begin
      q = make_query(int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 12)) - 6,
                     int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 12)) - 6,
                     int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 12)) - 6,
                     $urandom_range(0, 6), $urandom_range(0, 6));
    end else if (kind <= 8) begin
      w  = $urandom_range(0, (1 << $urandom_range(0, 15)) - 1);
      h  = ($urandom_range(0, 3) == 0) ? w : $urandom_range(0, (1 << $urandom_range(0, 15)) - 1);
      x0 = int'(coord_t'($urandom));
      y0 = int'(coord_t'($urandom));
      q = make_query(x0 - w / 2 + int'($urandom_range(0, 2 * w)),
                     y0 - h / 2 + int'($urandom_range(0, 2 * h)),
                     x0 - w / 2 + int'($urandom_range(0, 2 * w)),
                     y0 - h / 2 + int'($urandom_range(0, 2 * h)),
                     x0, y0, w, h);
    end else begin
      // Point segment on a corner, just above the far corner, or at the exact center of the rectangle.
      w  = 2 * $urandom_range(0, 2000);
      h  = 2 * $urandom_range(0, 2000);
      x0 = int'($urandom_range(0, 40000)) - 20000;
      y0 = int'($urandom_range(0, 40000)) - 20000;
      corner = $urandom_range(0, 4);
      case (corner)
        0: q = make_query(x0, y0, x0, y0, x0, y0, w, h);
        1: q = make_query(x0 + w, y0, x0 + w, y0, x0, y0, w, h);
        2: q = make_query(x0, y0 + h, x0, y0 + h, x0, y0, w, h);
        3: q = make_query(x0 + w, y0 + h + 1, x0 + w, y0 + h + 1, x0, y0, w, h);
        default: q = make_query(x0 + w / 2, y0 + h / 2, x0 + w / 2, y0 + h / 2,
                                x0, y0, w, h);
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, dense runs, and the one long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_request > 0) begin
        stall = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        if (rx_run_left == 0) begin
          rx_dense    = ($urandom_range(0, 3) == 0);
          rx_run_left = $urandom_range(10, 60);
        end
        rx_run_left--;
        stall = rx_dense ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      hits.check_hit(hit);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    query_t directed[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Q12.4 raw values: 16 is 1.0. Square 0..160 unless noted.
    directed.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0));            // point on point rect
    directed.push_back(make_query(0, 160, 160, 0, 0, 0, 160, 160));    // proper X crossing
    directed.push_back(make_query(1000, 1000, 2000, 1000, 0, 0, 160, 160)); // far miss
    directed.push_back(make_query(-32768, -32768, 32767, 32767,
                                  -32768, -32768, 32767, 32767));      // full-range overlap
    directed.push_back(make_query(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));        // corner past 16 bits
    directed.push_back(make_query(-32768, 32767, 32767, -32768,
                                  32767, -32768, 32767, 32767));
    directed.push_back(make_query(80, 80, 80, 80, 0, 0, 160, 160));    // point on diagonal
    directed.push_back(make_query(200, 200, 200, 200, 0, 0, 160, 160)); // point on extension
    directed.push_back(make_query(160, 160, 320, 320, 0, 0, 160, 160)); // collinear, endpoint touch
    directed.push_back(make_query(170, 170, 320, 320, 0, 0, 160, 160)); // collinear, disjoint
    directed.push_back(make_query(0, 10, 160, 170, 0, 0, 160, 160));   // parallel, offset
    directed.push_back(make_query(50, -10, 50, 300, 50, 0, 0, 160));   // zero width
    directed.push_back(make_query(-10, 40, 300, 40, 0, 40, 160, 0));   // zero height
    directed.push_back(make_query(0, 160, 0, 160, 0, 0, 0, 160));      // point at line end
    directed.push_back(make_query(100, 0, 200, 0, 0, 0, 160, 160));    // passes through a corner
    directed.push_back(make_query(-32768, 0, 32767, 0,
                                  -32768, -32768, 32767, 32767));
    directed.push_back(make_query(32767, -32768, -32768, 32767, 0, 0, 0, 0));
    directed.push_back(make_query(5, 5, 5, 5, 5, 5, 0, 0));            // equal points
    directed.push_back(make_query(5, 6, 5, 6, 5, 5, 0, 0));            // points one lsb apart
    directed.push_back(make_query(-1, -1, -1, -1, -32768, -32768, 32767, 32767));
    foreach (directed[i]) send_query(directed[i], 1'b0);

    // Sender pause until everything is back, then a long receiver hold-off
    // with back-to-back beats so the pipe fills and in_ready drops.
    drain_results();
    rx_hold_request = 150;
    repeat (40) send_query(random_query(), 1'b1);

    for (int n = 0; n < 800; n++) begin
      if (n == 400) drain_results();
      send_query(random_query(), 1'b0);
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (hits.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout watchdog: fails the run if the stimulus has not finished by then.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ segment_rectangle_diagonal_hit_core.f @@
rtl/srdh_pkg.sv
rtl/srdh_orient.sv
rtl/segment_rectangle_diagonal_hit_core.sv
dv/segment_rectangle_diagonal_hit_core_test.sv
